### rtl/morse_code_run_encoder_unit_assert.svh
// Assertion macros used by the Morse run encoder queue.
`ifndef MORSE_CODE_RUN_ENCODER_UNIT_ASSERT_SVH
`define MORSE_CODE_RUN_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising clock edge outside reset.
`define MCRE_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("mcre assertion failed");
// Next-cycle implication, checked on the rising clock edge outside reset.
`define MCRE_ASSERT_NXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("mcre assertion failed");
`else
`define MCRE_ASSERT_IMP(label, cond, prop)
`define MCRE_ASSERT_NXT(label, cond, prop)
`endif
`endif

### rtl/mcre_pkg.sv
// Types, constants and the letter table of the Morse run encoder.
`timescale 1ns / 1ps
package mcre_pkg;

   // One character's work, as handed from front to back
   typedef struct packed {
      logic       gap_en;     // a leading silence run is due
      logic       gap_word;   // 1: word gap, 0: letter gap
      logic [2:0] elem_cnt;   // number of marks, 0 to 4
      logic [3:0] pattern;    // bit i set: mark i is a dash
   } desc_type;

   // Timing registers
   typedef struct packed {
      logic [7:0] dot_ticks;
      logic [7:0] dash_ticks;
      logic [7:0] letter_gap_ticks;
      logic [7:0] word_gap_ticks;
   } cfg_type;

   // Register indexes
   localparam logic [1:0] REG_DOT_TICKS        = 2'd0;
   localparam logic [1:0] REG_DASH_TICKS       = 2'd1;
   localparam logic [1:0] REG_LETTER_GAP_TICKS = 2'd2;
   localparam logic [1:0] REG_WORD_GAP_TICKS   = 2'd3;

   // Character codes
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Silence between the marks of one letter
   localparam logic [7:0] ELEM_GAP_TICKS = 8'd1;

   // Letter table: {mark count, dash pattern} for A..Z
   function automatic logic [6:0] letter_code(input logic [4:0] idx);
      logic [6:0] code;
      unique case (idx)
         5'd0:    code = {3'd2, 4'h2};
         5'd1:    code = {3'd4, 4'h1};
         5'd2:    code = {3'd4, 4'h5};
         5'd3:    code = {3'd3, 4'h1};
         5'd4:    code = {3'd1, 4'h0};
         5'd5:    code = {3'd4, 4'h4};
         5'd6:    code = {3'd3, 4'h3};
         5'd7:    code = {3'd4, 4'h0};
         5'd8:    code = {3'd2, 4'h0};
         5'd9:    code = {3'd4, 4'hE};
         5'd10:   code = {3'd3, 4'h5};
         5'd11:   code = {3'd4, 4'h2};
         5'd12:   code = {3'd2, 4'h3};
         5'd13:   code = {3'd2, 4'h1};
         5'd14:   code = {3'd3, 4'h7};
         5'd15:   code = {3'd4, 4'h6};
         5'd16:   code = {3'd4, 4'hB};
         5'd17:   code = {3'd3, 4'h2};
         5'd18:   code = {3'd3, 4'h0};
         5'd19:   code = {3'd1, 4'h1};
         5'd20:   code = {3'd3, 4'h4};
         5'd21:   code = {3'd4, 4'h8};
         5'd22:   code = {3'd3, 4'h6};
         5'd23:   code = {3'd4, 4'h9};
         5'd24:   code = {3'd4, 4'hD};
         5'd25:   code = {3'd4, 4'h3};
         default: code = 7'd0;
      endcase
      return code;
   endfunction

endpackage

### rtl/morse_code_run_encoder_unit.sv
// Top level of the Morse run encoder: timing registers, front, queue and back.
//
//   Channel | Direction | Word contents
//   req     | in        | tdata[7:0] char_code, tuser[0] message_start
//   rsp     | out       | tdata[7:0] run_ticks, tuser[0] level, tlast last_run
//   csr     | in        | csr_index register, csr_wdata[7:0] value
//
// The front takes one character per cycle while the queue has room.
// The back sends one run per cycle while rsp_tready allows, so a character costs
// its run count, 1 to 8 runs (leading gap plus 2*marks-1); the back is the limit.
// Accept to first run: queue, descriptor registers, then the output register.
// Reset is synchronous; a stalled rsp side fills the queue, then drops req_tready.
`timescale 1ns / 1ps
module morse_code_run_encoder_unit
   import mcre_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] char_code
   input  logic [0:0] req_tuser,    // [0] message_start
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] run_ticks
   output logic [0:0] rsp_tuser,    // [0] level
   output logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   desc_type push_desc, pop_desc;
   logic     push, pop, q_full, q_empty;

   // Timing registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DOT_TICKS:        cfg_in.dot_ticks        = csr_wdata;
            REG_DASH_TICKS:       cfg_in.dash_ticks       = csr_wdata;
            REG_LETTER_GAP_TICKS: cfg_in.letter_gap_ticks = csr_wdata;
            REG_WORD_GAP_TICKS:   cfg_in.word_gap_ticks   = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_ticks        <= 8'd1;
         cfg_ff.dash_ticks       <= 8'd3;
         cfg_ff.letter_gap_ticks <= 8'd3;
         cfg_ff.word_gap_ticks   <= 8'd7;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_desc  (push_desc)
   );

   mcre_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   mcre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_desc     (pop_desc),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/mcre_front.sv
// Front end: takes characters, folds case, tracks letter spacing, builds descriptors.
`timescale 1ns / 1ps
module mcre_front
   import mcre_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic [0:0] req_tuser,   // [0] message_start
   input  logic       q_full,
   output logic       push,
   output desc_type   push_desc
);

   logic       prev_ff, prev_in;
   logic [7:0] folded;
   logic       is_space, is_letter, prev_eff;
   logic [4:0] letter_idx;
   logic [6:0] code;
   logic       accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // Classify the character
   always_comb begin
      folded = req_tdata;
      if (req_tdata >= CHAR_LOWER_A && req_tdata <= CHAR_LOWER_Z) begin
         folded = req_tdata - CASE_OFFSET;
      end
      is_space   = (folded == CHAR_SPACE);
      is_letter  = (folded >= CHAR_UPPER_A) && (folded <= CHAR_UPPER_Z);
      letter_idx = 5'(folded - CHAR_UPPER_A);
      code       = letter_code(letter_idx);
      prev_eff   = prev_ff && !req_tuser[0];

      push_desc.gap_en   = is_space || prev_eff;
      push_desc.gap_word = is_space;
      push_desc.elem_cnt = (is_letter && !is_space) ? code[6:4] : 3'd0;
      push_desc.pattern  = code[3:0];

      // A character with no runs at all is dropped here
      push    = accept && (push_desc.gap_en || (push_desc.elem_cnt != 3'd0));
      prev_in = accept ? !is_space : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

### rtl/mcre_queue.sv
// Small descriptor queue between the front and back ends.
`timescale 1ns / 1ps
module mcre_queue
   import mcre_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output desc_type pop_desc,
   output logic     full,
   output logic     empty
);
`include "morse_code_run_encoder_unit_assert.svh"

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   desc_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_desc = mem_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   `MCRE_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CW'(DEPTH))
   `MCRE_ASSERT_IMP(a_no_pop_empty, pop, count_ff != '0)
   `MCRE_ASSERT_NXT(a_count_up, push && !pop, count_ff == $past(count_ff) + CW'(1))

endmodule

### rtl/mcre_back.sv
// Back end: walks one descriptor into runs, one run per cycle while rsp_tready allows, into the output register.
`timescale 1ns / 1ps
module mcre_back
   import mcre_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_empty,
   input  desc_type   q_desc,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] run_ticks
   output logic [0:0] rsp_tuser,   // [0] level
   output logic       rsp_tlast
);

   // Descriptor being worked
   logic       cur_ff, cur_in;
   logic       gap_ff, gap_in;
   logic       word_ff, word_in;
   logic       sep_ff, sep_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [3:0] pat_ff, pat_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] ticks_ff, ticks_in;
   logic       level_ff, level_in;
   logic       last_ff, last_in;

   logic       run_level, run_last, emit;
   logic [7:0] run_ticks;

   // Next run of the current descriptor
   always_comb begin
      if (gap_ff) begin
         run_level = 1'b0;
         run_ticks = word_ff ? cfg.word_gap_ticks : cfg.letter_gap_ticks;
         run_last  = (cnt_ff == 3'd0);
      end else if (sep_ff) begin
         run_level = 1'b0;
         run_ticks = ELEM_GAP_TICKS;
         run_last  = 1'b0;
      end else begin
         run_level = 1'b1;
         run_ticks = pat_ff[0] ? cfg.dash_ticks : cfg.dot_ticks;
         run_last  = (cnt_ff == 3'd1);
      end
   end

   assign emit = cur_ff && (!rsp_valid_ff || rsp_tready);
   assign pop  = !q_empty && (!cur_ff || (emit && run_last));

   // Sequencer and output register next values
   always_comb begin
      cur_in       = cur_ff;
      gap_in       = gap_ff;
      word_in      = word_ff;
      sep_in       = sep_ff;
      cnt_in       = cnt_ff;
      pat_in       = pat_ff;
      rsp_valid_in = rsp_valid_ff;
      ticks_in     = ticks_ff;
      level_in     = level_ff;
      last_in      = last_ff;

      if (emit) begin
         rsp_valid_in = 1'b1;
         ticks_in     = run_ticks;
         level_in     = run_level;
         last_in      = run_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (pop) begin
         cur_in  = 1'b1;
         gap_in  = q_desc.gap_en;
         word_in = q_desc.gap_word;
         sep_in  = 1'b0;
         cnt_in  = q_desc.elem_cnt;
         pat_in  = q_desc.pattern;
      end else if (emit) begin
         cur_in = !run_last;
         if (gap_ff) begin
            gap_in = 1'b0;
         end else if (sep_ff) begin
            sep_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 3'd1;
            pat_in = {1'b0, pat_ff[3:1]};
            sep_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gap_ff   <= gap_in;
      word_ff  <= word_in;
      sep_ff   <= sep_in;
      cnt_ff   <= cnt_in;
      pat_ff   <= pat_in;
      ticks_ff <= ticks_in;
      level_ff <= level_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = ticks_ff;
   assign rsp_tuser[0] = level_ff;
   assign rsp_tlast    = last_ff;

endmodule
